FILE: hdl/note_velocity_accent_defines.svh
// Assertion helpers shared by the note velocity accent block.
`ifndef NOTE_VELOCITY_ACCENT_DEFINES_SVH
`define NOTE_VELOCITY_ACCENT_DEFINES_SVH

// The condition must hold at every clock edge outside reset.
`define NVA_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// When the trigger holds, the outcome must hold in the following cycle.
`define NVA_NEXT(lbl, trig, outcome, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (outcome)) else $error(msg);

`endif

FILE: hdl/nva_pkg.sv
`timescale 1ns / 1ps

package nva_pkg;

    // Gains are unsigned Q3.13.
    localparam logic [15:0] UNITY_GAIN = 16'd8192;
    localparam int          DVD_W      = 48;
    localparam int          DVS_W      = 30;
    localparam int          TIME_W     = 39;

    // Configuration register indexes.
    localparam logic [2:0] REG_MARKS   = 3'd0;
    localparam logic [2:0] REG_PLEN    = 3'd1;
    localparam logic [2:0] REG_STEP    = 3'd2;
    localparam logic [2:0] REG_STRONG  = 3'd3;
    localparam logic [2:0] REG_WEAK    = 3'd4;
    localparam logic [2:0] REG_BAR     = 3'd5;
    localparam logic [2:0] REG_SSTART  = 3'd6;
    localparam logic [2:0] REG_SEND    = 3'd7;

    // One classified item waiting in the queue.
    typedef struct packed {
        logic              is_note;
        logic [TIME_W-1:0] ev_time;
        logic [6:0]        vel;
    } t_item;

    typedef struct packed {
        logic [63:0] marks;
        logic [6:0]  plen;
        logic [25:0] step_len;
        logic [15:0] gain_mark;
        logic [15:0] gain_plain;
        logic [29:0] bar_len;
        logic [15:0] sw_start;
        logic [15:0] sw_end;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DVD_W-1:0] quotient;
        logic [DVS_W-1:0] remainder;
    } t_div_rsp;

endpackage

FILE: hdl/nva_front.sv
`timescale 1ns / 1ps

module nva_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_is_note,
    input  logic [39:0]   i_ev_time,
    input  logic [6:0]    i_vel,
    output logic          o_q_valid,
    output nva_pkg::t_item o_q_item,
    input  logic          i_q_pop
);
    import nva_pkg::*;

    localparam int DEPTH = 4;

    t_item      r_mem [DEPTH];
    logic [1:0] r_wr_ptr, r_rd_ptr;
    logic [2:0] r_count;
    logic       push;
    t_item      item_in;

    // Negative times count as zero.
    always_comb begin
        item_in.is_note = i_is_note;
        item_in.ev_time = i_ev_time[39] ? '0 : i_ev_time[TIME_W-1:0];
        item_in.vel     = i_vel;
    end

    assign o_ready   = (r_count != 3'(DEPTH));
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_count != 3'd0);
    assign o_q_item  = r_mem[r_rd_ptr];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= item_in;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 2'd1;
            end
            if (i_q_pop) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_count <= r_count + 3'(push) - 3'(i_q_pop);
        end
    end

endmodule

FILE: hdl/nva_div.sv
`timescale 1ns / 1ps

module nva_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  nva_pkg::t_div_req i_req,
    output nva_pkg::t_div_rsp o_rsp
);
    import nva_pkg::*;

    logic [DVD_W-1:0] r_dvd;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W-1:0] r_rem;
    logic [5:0]       r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;

    // One quotient bit per cycle, restoring.
    assign trial = {r_rem, r_dvd[DVD_W-1]};
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd <= i_req.dividend;
            r_dvs <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            if (!diff[DVS_W]) begin
                r_rem <= diff[DVS_W-1:0];
                r_dvd <= {r_dvd[DVD_W-2:0], 1'b1};
            end else begin
                r_rem <= trial[DVS_W-1:0];
                r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(DVD_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.busy      = r_busy;
    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_dvd;
    assign o_rsp.remainder = r_rem;

endmodule

FILE: hdl/nva_back.sv
`timescale 1ns / 1ps

`include "note_velocity_accent_defines.svh"

module nva_back #(
    parameter int MAX_STEPS = 64
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  nva_pkg::t_cfg  i_cfg,
    input  logic           i_q_valid,
    input  nva_pkg::t_item i_q_item,
    output logic           o_q_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [6:0]     o_vel
);
    import nva_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_QDIV   = 4'd1;
    localparam logic [3:0] S_LDIV   = 4'd2;
    localparam logic [3:0] S_SW     = 4'd3;
    localparam logic [3:0] S_PDIV   = 4'd4;
    localparam logic [3:0] S_PMUL   = 4'd5;
    localparam logic [3:0] S_GSTART = 4'd6;
    localparam logic [3:0] S_GDIV   = 4'd7;
    localparam logic [3:0] S_M1     = 4'd8;
    localparam logic [3:0] S_M2     = 4'd9;
    localparam logic [3:0] S_RND    = 4'd10;
    localparam logic [3:0] S_OUT    = 4'd11;

    logic [3:0]  r_state, n_state;
    t_item       r_item;
    logic [6:0]  r_len;
    logic [15:0] r_pg, r_sg;
    logic [29:0] r_phase;
    logic [45:0] r_num;
    logic [22:0] r_p1;
    logic [38:0] r_p2;
    logic [6:0]  r_res;
    logic        r_ovalid;
    logic [6:0]  r_vel;

    t_div_req    div_req;
    t_div_rsp    div_rsp;
    logic [6:0]  len_sat;
    logic        sw_neg;
    logic [15:0] abs_diff;
    logic [39:0] rounded;
    logic [13:0] scaled;
    logic        out_free;

    nva_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign len_sat  = (i_cfg.plen > 7'(MAX_STEPS)) ? 7'(MAX_STEPS) : i_cfg.plen;
    assign sw_neg   = i_cfg.sw_end < i_cfg.sw_start;
    assign abs_diff = sw_neg ? (i_cfg.sw_start - i_cfg.sw_end)
                             : (i_cfg.sw_end - i_cfg.sw_start);
    assign rounded  = {1'b0, r_p2} + 40'(1 << 25);
    assign scaled   = rounded[39:26];
    assign out_free = !r_ovalid || i_ready;
    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;

    // Sequencer: next state and divider requests.
    always_comb begin
        n_state          = r_state;
        div_req.start    = 1'b0;
        div_req.dividend = {9'b0, r_item.ev_time};
        div_req.divisor  = {4'b0, i_cfg.step_len};
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    if (!i_q_item.is_note) begin
                        n_state = S_OUT;
                    end else if (len_sat == 7'd0 || i_cfg.step_len == 26'd0) begin
                        n_state = S_SW;
                    end else begin
                        div_req.start    = 1'b1;
                        div_req.dividend = {9'b0, i_q_item.ev_time};
                        n_state          = S_QDIV;
                    end
                end
            end
            S_QDIV: begin
                if (div_rsp.done) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = div_rsp.quotient;
                    div_req.divisor  = {23'b0, r_len};
                    n_state          = S_LDIV;
                end
            end
            S_LDIV: begin
                if (div_rsp.done) begin
                    n_state = S_SW;
                end
            end
            S_SW: begin
                if (i_cfg.sw_start == i_cfg.sw_end || i_cfg.bar_len == 30'd0) begin
                    n_state = S_M1;
                end else begin
                    div_req.start   = 1'b1;
                    div_req.divisor = i_cfg.bar_len;
                    n_state         = S_PDIV;
                end
            end
            S_PDIV: begin
                if (div_rsp.done) begin
                    n_state = S_PMUL;
                end
            end
            S_PMUL:   n_state = S_GSTART;
            S_GSTART: begin
                div_req.start    = 1'b1;
                div_req.dividend = {2'b0, r_num};
                div_req.divisor  = i_cfg.bar_len;
                n_state          = S_GDIV;
            end
            S_GDIV: begin
                if (div_rsp.done) begin
                    n_state = S_M1;
                end
            end
            S_M1:  n_state = S_M2;
            S_M2:  n_state = S_RND;
            S_RND: n_state = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_item <= i_q_item;
            r_len  <= len_sat;
            r_pg   <= UNITY_GAIN;
            r_res  <= i_q_item.vel;
        end
        if (r_state == S_LDIV && div_rsp.done) begin
            r_pg <= i_cfg.marks[div_rsp.remainder[5:0]] ? i_cfg.gain_mark
                                                         : i_cfg.gain_plain;
        end
        if (r_state == S_SW) begin
            r_sg <= (i_cfg.sw_start == i_cfg.sw_end) ? i_cfg.sw_start : UNITY_GAIN;
        end
        if (r_state == S_PDIV && div_rsp.done) begin
            r_phase <= div_rsp.remainder;
        end
        if (r_state == S_PMUL) begin
            r_num <= abs_diff * r_phase;
        end
        // The quotient stays below the gain difference, so the sum never goes negative.
        if (r_state == S_GDIV && div_rsp.done) begin
            r_sg <= sw_neg ? (i_cfg.sw_start - div_rsp.quotient[15:0])
                           : (i_cfg.sw_start + div_rsp.quotient[15:0]);
        end
        if (r_state == S_M1) begin
            r_p1 <= r_item.vel * r_pg;
        end
        if (r_state == S_M2) begin
            r_p2 <= r_p1 * r_sg;
        end
        // Round half up and clamp to 1..127.
        if (r_state == S_RND) begin
            if (scaled == 14'd0) begin
                r_res <= 7'd1;
            end else if (scaled > 14'd127) begin
                r_res <= 7'd127;
            end else begin
                r_res <= scaled[6:0];
            end
        end
        if (r_state == S_OUT && out_free) begin
            r_vel <= r_res;
        end
    end

    // Control state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_vel   = r_vel;

    `NVA_ALWAYS(a_div_no_restart, !(div_req.start && div_rsp.busy), "divider restarted while busy")
    `NVA_NEXT(a_pop_leaves_idle, o_q_pop, r_state != S_IDLE, "sequencer stayed idle after pop")
    `NVA_NEXT(a_note_nonzero, r_state == S_RND, r_res != 7'd0, "note velocity rounded to zero")

endmodule

FILE: hdl/note_velocity_accent.sv
`timescale 1ns / 1ps

// Note velocity accent: scales each note's velocity by a step pattern gain
// and a linear swell across the bar, then rounds and clamps it to 1..127.
// Input items arrive on the s_axis channel: tdata carries event_time and
// velocity_in, tuser carries is_note. Results leave on m_axis, one per item,
// in order. A four-entry queue takes one item per cycle, while not full, as
// the back end works. A non-note item passes through the output state to
// m_axis; the back end takes a new item only once the last is in the output
// register. A note that needs no division goes through S_SW, S_M1, S_M2,
// S_RND and S_OUT. A note costs up to four passes through a shared restoring
// divider (step index, pattern position, bar phase, swell interpolation),
// plus the multiply and round steps; the divider sets the sustained rate for
// notes. When m_axis_tready is low the finished result holds in the output
// register and the back end waits; the queue keeps filling until full and
// then drops s_axis_tready. Reset empties the queue and output and loads the
// register defaults. Configuration writes land at once; the user must make
// them only while the block is idle, which the block itself does not enforce.
module note_velocity_accent #(
    parameter int MAX_STEPS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [39:0] event_time, [46:40] velocity_in
    input  logic        s_axis_tuser,   // [0] is_note
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [6:0] velocity_out
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import nva_pkg::*;

    t_cfg       r_cfg;
    logic       q_valid;
    logic       q_pop;
    t_item      q_item;
    logic [6:0] vel_out;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.marks      <= '0;
            r_cfg.plen       <= '0;
            r_cfg.step_len   <= 26'd250000;
            r_cfg.gain_mark  <= 16'd9421;
            r_cfg.gain_plain <= 16'd6963;
            r_cfg.bar_len    <= 30'd2000000;
            r_cfg.sw_start   <= UNITY_GAIN;
            r_cfg.sw_end     <= UNITY_GAIN;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MARKS:  r_cfg.marks      <= i_cfg_data;
                REG_PLEN:   r_cfg.plen       <= i_cfg_data[6:0];
                REG_STEP:   r_cfg.step_len   <= i_cfg_data[25:0];
                REG_STRONG: r_cfg.gain_mark  <= i_cfg_data[15:0];
                REG_WEAK:   r_cfg.gain_plain <= i_cfg_data[15:0];
                REG_BAR:    r_cfg.bar_len    <= i_cfg_data[29:0];
                REG_SSTART: r_cfg.sw_start   <= i_cfg_data[15:0];
                REG_SEND:   r_cfg.sw_end     <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    nva_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_is_note (s_axis_tuser),
        .i_ev_time (s_axis_tdata[39:0]),
        .i_vel     (s_axis_tdata[46:40]),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    nva_back #(
        .MAX_STEPS (MAX_STEPS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_vel     (vel_out)
    );

    assign m_axis_tdata = {1'b0, vel_out};

endmodule

FILE: tb/note_velocity_accent_tb.sv
`timescale 1ns / 1ps

// Scoreboard: predicts each output velocity from the register copy it holds.
class velocity_scoreboard;
    logic [63:0] marks;
    logic [6:0]  plen;
    logic [25:0] step_len;
    logic [15:0] gain_mark;
    logic [15:0] gain_plain;
    logic [29:0] bar_len;
    logic [15:0] sw_start;
    logic [15:0] sw_end;
    logic [6:0]  expected_vel[$];
    int          errors;

    function new();
        errors = 0;
        load_defaults();
    endfunction

    function void load_defaults();
        marks = 64'd0;
        plen = 7'd0;
        step_len = 26'd250000;
        gain_mark = 16'd9421;
        gain_plain = 16'd6963;
        bar_len = 30'd2000000;
        sw_start = 16'd8192;
        sw_end = 16'd8192;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] val);
        case (idx)
            nva_pkg::REG_MARKS:  marks = val;
            nva_pkg::REG_PLEN:   plen = val[6:0];
            nva_pkg::REG_STEP:   step_len = val[25:0];
            nva_pkg::REG_STRONG: gain_mark = val[15:0];
            nva_pkg::REG_WEAK:   gain_plain = val[15:0];
            nva_pkg::REG_BAR:    bar_len = val[29:0];
            nva_pkg::REG_SSTART: sw_start = val[15:0];
            nva_pkg::REG_SEND:   sw_end = val[15:0];
            default: ;
        endcase
    endfunction

    function logic [6:0] weigh_velocity(logic is_note, logic [39:0] t_raw, logic [6:0] vel);
        longint unsigned t;
        longint unsigned len;
        longint unsigned step;
        longint unsigned pgain;
        longint unsigned sgain;
        longint unsigned prod;
        longint unsigned v;
        longint          g;
        if (!is_note) return vel;
        t = t_raw[39] ? 0 : {25'd0, t_raw[38:0]};
        len = (plen > 64) ? 64 : plen;
        if (len == 0 || step_len == 0) begin
            pgain = 8192;
        end else begin
            step = (t / step_len) % len;
            pgain = marks[step[5:0]] ? gain_mark : gain_plain;
        end
        if (sw_start == sw_end) begin
            sgain = sw_start;
        end else if (bar_len == 0) begin
            sgain = 8192;
        end else begin
            g = longint'(sw_start) + ((longint'(sw_end) - longint'(sw_start)) *
                longint'(t % bar_len)) / longint'(bar_len);
            sgain = (g < 0) ? 0 : g;
        end
        prod = vel * pgain * sgain;
        v = (prod + (64'd1 << 25)) >> 26;
        if (v < 1) v = 1;
        if (v > 127) v = 127;
        return v[6:0];
    endfunction

    function void note_input(logic is_note, logic [39:0] t_raw, logic [6:0] vel);
        expected_vel.push_back(weigh_velocity(is_note, t_raw, vel));
    endfunction

    task report(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    task check_result(logic [7:0] data);
        logic [6:0] want;
        if (expected_vel.size() == 0) begin
            report($sformatf("unexpected result %0d", data[6:0]));
            return;
        end
        want = expected_vel.pop_front();
        if (data[6:0] !== want)
            report($sformatf("velocity_out got %0d want %0d", data[6:0], want));
    endtask
endclass

module note_velocity_accent_tb;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata = '0;   // [39:0] event_time, [46:40] velocity_in
    logic        s_axis_tuser = 1'b0; // [0] is_note
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // [6:0] velocity_out
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    velocity_scoreboard sb = new();

    note_velocity_accent dut (.*);

    always #5 i_clk = ~i_clk;

    // Receiver: random ready, results checked at the rising edge.
    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge i_clk)
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);

    // Register write; the block is idle whenever this is called.
    task automatic write_cfg(logic [2:0] idx, logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    // Send one item and hold it until accepted.
    task automatic send_item(logic is_note, logic [39:0] t, logic [6:0] vel);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= is_note;
        s_axis_tdata <= {1'b0, vel, t};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_input(is_note, t, vel);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_vel.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // Random time: mostly small positive, some huge and some negative.
    function automatic logic [39:0] rand_time();
        case ($urandom_range(9))
            0: return 40'({$urandom, $urandom});
            1: return {1'b1, 39'({$urandom, $urandom})};
            2: return 40'({$urandom_range(255), $urandom}) & 40'h7F_FFFF_FFFF;
            default: return 40'($urandom_range(50000000));
        endcase
    endfunction

    task automatic rand_config(bit extreme);
        write_cfg(nva_pkg::REG_MARKS, {$urandom, $urandom});
        write_cfg(nva_pkg::REG_PLEN, extreme ? 7'($urandom_range(1) ? 127 : 64)
                                             : 7'($urandom_range(64)));
        write_cfg(nva_pkg::REG_STEP, extreme ? ($urandom_range(1) ? 26'h3FFFFFF : 26'd0)
                                             : 26'($urandom_range(60000000, 10000)));
        write_cfg(nva_pkg::REG_STRONG, extreme ? 16'hFFFF : 16'($urandom_range(32768)));
        write_cfg(nva_pkg::REG_WEAK, extreme ? 16'd0 : 16'($urandom_range(32768)));
        write_cfg(nva_pkg::REG_BAR, extreme ? ($urandom_range(1) ? 30'h3FFFFFFF : 30'd0)
                                            : 30'($urandom_range(600000000, 50000)));
        write_cfg(nva_pkg::REG_SSTART, extreme ? 16'hFFFF : 16'($urandom_range(32768)));
        write_cfg(nva_pkg::REG_SEND, extreme ? 16'd0 : 16'($urandom_range(32768)));
    endtask

    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part with default registers, then with a pattern.
        send_item(1'b1, 40'd0, 7'd127);
        send_item(1'b1, 40'd0, 7'd0);
        send_item(1'b0, 40'hFF_FFFF_FFFF, 7'd85);
        send_item(1'b1, 40'h80_0000_0000, 7'd64);
        send_item(1'b1, 40'h7F_FFFF_FFFF, 7'd127);
        drain();
        write_cfg(nva_pkg::REG_MARKS, 64'h8000_0000_0000_0001);
        write_cfg(nva_pkg::REG_PLEN, 7'd64);
        write_cfg(nva_pkg::REG_SSTART, 16'd0);
        write_cfg(nva_pkg::REG_SEND, 16'd32768);
        for (int i = 0; i < 6; i++)
            send_item(1'b1, 40'(i * 250000 + 1999999 * (i & 1)), 7'(i * 25 + 2));
        send_item(1'b1, 40'd15750000, 7'd100);
        drain();
        // Zero step length and zero bar length give unity.
        write_cfg(nva_pkg::REG_STEP, 26'd0);
        write_cfg(nva_pkg::REG_BAR, 30'd0);
        send_item(1'b1, 40'd123456, 7'd99);
        drain();
        // Oversized pattern length saturates; large gains drive the velocity to its clamp.
        write_cfg(nva_pkg::REG_PLEN, 7'd127);
        write_cfg(nva_pkg::REG_STEP, 26'd10000);
        write_cfg(nva_pkg::REG_STRONG, 16'hFFFF);
        write_cfg(nva_pkg::REG_BAR, 30'd50000);
        send_item(1'b1, 40'd640000, 7'd127);
        send_item(1'b1, 40'd10000, 7'd1);
        drain();

        // Random part over three idling regimes.
        for (int ph = 0; ph < 12; ph++) begin
            send_idle_pct = (ph < 4) ? 17 : (ph < 8) ? 48 : 0;
            recv_idle_pct = (ph < 4) ? 48 : (ph < 8) ? 17 : 0;
            rand_config(ph % 4 == 3);
            for (int i = 0; i < 120; i++)
                send_item($urandom_range(9) != 0, rand_time(), 7'($urandom));
            drain();
        end

        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

FILE: files.f
+incdir+hdl
hdl/nva_pkg.sv
hdl/nva_front.sv
hdl/nva_div.sv
hdl/nva_back.sv
hdl/note_velocity_accent.sv
tb/note_velocity_accent_tb.sv
